[src/sue_pkg.sv]
`timescale 1ns / 1ps

package sue_pkg;

  // Default sizing of the result store.
  localparam int DEPTH_DEF      = 256;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int POS_W = 8;
  localparam int CNT_W = 9;

  // Request commands. The unused code behaves as a second-list append.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SECOND = 2'd2;

  // Result status codes.
  localparam logic [STS_W-1:0] ST_APPENDED  = 2'd0;
  localparam logic [STS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STS_W-1:0] ST_CLEARED   = 2'd3;

  // Control part of the search token that walks down the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

endpackage

[src/sue_cell.sv]
`timescale 1ns / 1ps

module sue_cell #(
  parameter int EW    = sue_pkg::ELEM_WIDTH_DEF,
  parameter int AW    = 8,
  parameter int CW    = 9,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  sue_pkg::tok_t       tok_in,
  input  logic [EW-1:0]       key_in,
  input  logic [AW-1:0]       pos_in,
  input  logic [CW-1:0]       stored_count,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [EW-1:0]       wr_data,
  output sue_pkg::tok_t       tok_out,
  output logic [EW-1:0]       key_out,
  output logic [AW-1:0]       pos_out
);

  logic [EW-1:0] entry;
  logic          match;

  // This cell owns one slot of the store.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == AW'(INDEX))) begin
      entry <= wr_data;
    end
  end

  // Only the first live entry that equals the key counts as the match.
  assign match = tok_in.valid && !tok_in.found && (CW'(INDEX) < stored_count) &&
                 (entry == key_in);

  // Token control advances one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | match;
    end
  end

  // Key and match slot travel with the token.
  always_ff @(posedge clk) begin
    key_out <= key_in;
    pos_out <= match ? AW'(INDEX) : pos_in;
  end

endmodule

[src/set_union_engine.sv]
`timescale 1ns / 1ps

// Set union engine: keeps a list of up to DEPTH elements, one per cell of a
// chain. A clear request empties the list, a first-list element is appended
// unchecked, and a second-list element is appended only when no stored entry
// equals it. One request is handled at a time. A clear or first-list request
// goes from idle to the done state; a second-list request first waits in the
// search state while its key walks down the chain of DEPTH cells, one cell
// per cycle, collecting the lowest matching slot. A finished result sits in
// an output register, so the next request is taken while it waits.
module set_union_engine #(
  parameter int DEPTH      = sue_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = sue_pkg::ELEM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sue_pkg::CMD_W-1:0] cmd,
  input  logic signed [sue_pkg::VAL_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sue_pkg::STS_W-1:0] status,
  output logic signed [sue_pkg::VAL_W-1:0] echo_value,
  output logic [sue_pkg::POS_W-1:0] position,
  output logic [sue_pkg::CNT_W-1:0] count
);

  localparam int EW  = ELEM_WIDTH;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = sue_pkg::POS_W;
  localparam int NW  = sue_pkg::CNT_W;
  localparam int VW  = sue_pkg::VAL_W;

  sue_pkg::state_t state, state_next;

  logic [sue_pkg::CMD_W-1:0] item_cmd;
  logic signed [VW-1:0]      item_value;
  logic                      found;
  logic [AW-1:0]             found_pos;
  logic [CW-1:0]             stored_count, stored_count_next;

  logic accept, inject, finish, search_done;
  logic item_search, in_search, full;
  logic wr_en;
  logic [EW-1:0] item_key;

  logic [sue_pkg::STS_W-1:0] status_next;
  logic [AW-1:0]             pos_next;

  sue_pkg::tok_t        tok [0:DEPTH];
  logic [EW-1:0]        key [0:DEPTH];
  logic [AW-1:0]        pos [0:DEPTH];

  assign accept      = in_valid && in_ready;
  assign in_search   = (cmd != sue_pkg::CMD_CLEAR) && (cmd != sue_pkg::CMD_FIRST);
  assign item_search = (item_cmd != sue_pkg::CMD_CLEAR) && (item_cmd != sue_pkg::CMD_FIRST);
  assign item_key    = EW'($unsigned(item_value));
  assign full        = (stored_count == CW'(DEPTH));
  assign search_done = tok[DEPTH].valid;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      sue_pkg::S_IDLE: begin
        if (accept) begin
          state_next = in_search ? sue_pkg::S_SEARCH : sue_pkg::S_DONE;
        end
      end
      sue_pkg::S_SEARCH: begin
        if (search_done) begin
          state_next = sue_pkg::S_DONE;
        end
      end
      sue_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = sue_pkg::S_IDLE;
        end
      end
      default: state_next = sue_pkg::S_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    in_ready = 1'b0;
    inject   = 1'b0;
    finish   = 1'b0;
    unique case (state)
      sue_pkg::S_IDLE: begin
        in_ready = 1'b1;
        inject   = in_valid && in_search;
      end
      sue_pkg::S_SEARCH: begin
        in_ready = 1'b0;
      end
      sue_pkg::S_DONE: begin
        finish = !out_valid || out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sue_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd   <= cmd;
      item_value <= value;
    end
  end

  // Capture the search outcome at the end of the chain. A first-list or
  // clear request never sees a found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if ((state == sue_pkg::S_SEARCH) && search_done) begin
      found <= tok[DEPTH].found;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == sue_pkg::S_SEARCH) && search_done) begin
      found_pos <= pos[DEPTH];
    end
  end

  // Result and store update for the finishing request.
  always_comb begin
    wr_en             = 1'b0;
    status_next       = sue_pkg::ST_APPENDED;
    pos_next          = '0;
    stored_count_next = stored_count;
    if (item_cmd == sue_pkg::CMD_CLEAR) begin
      status_next       = sue_pkg::ST_CLEARED;
      stored_count_next = '0;
    end else if (item_search && found) begin
      status_next = sue_pkg::ST_DUPLICATE;
      pos_next    = found_pos;
    end else if (full) begin
      status_next = sue_pkg::ST_FULL;
    end else begin
      wr_en             = finish;
      pos_next          = stored_count[AW-1:0];
      stored_count_next = stored_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else if (finish) begin
      stored_count <= stored_count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status     <= status_next;
      echo_value <= (item_cmd == sue_pkg::CMD_CLEAR) ? '0 : item_value;
      position   <= PW'(pos_next);
      count      <= NW'(stored_count_next);
    end
  end

  // Token entering the first cell.
  assign tok[0].valid = inject;
  assign tok[0].found = 1'b0;
  assign key[0]       = EW'($unsigned(value));
  assign pos[0]       = '0;

  // The cell chain: one stored entry per cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sue_cell #(
      .EW    (EW),
      .AW    (AW),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (tok[i]),
      .key_in       (key[i]),
      .pos_in       (pos[i]),
      .stored_count (stored_count),
      .wr_en        (wr_en),
      .wr_addr      (stored_count[AW-1:0]),
      .wr_data      (item_key),
      .tok_out      (tok[i+1]),
      .key_out      (key[i+1]),
      .pos_out      (pos[i+1])
    );
  end

endmodule

[src/sue_checker.sv]
`timescale 1ns / 1ps

module sue_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [sue_pkg::CMD_W-1:0] cmd,
  input logic signed [sue_pkg::VAL_W-1:0] value,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sue_pkg::STS_W-1:0] status,
  input logic signed [sue_pkg::VAL_W-1:0] echo_value,
  input logic [sue_pkg::POS_W-1:0] position,
  input logic [sue_pkg::CNT_W-1:0] count
);

  // A cleared list reports an empty store and zero fields.
  a_clear_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sue_pkg::ST_CLEARED) |->
      (count == '0) && (position == '0) && (echo_value == '0))
    else $error("clear result with nonzero fields");

  // An appended element lands in the last occupied slot.
  a_append_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sue_pkg::ST_APPENDED) |->
      (count != '0) && (position == sue_pkg::POS_W'(count - sue_pkg::CNT_W'(1))))
    else $error("appended slot does not match count");

  // A dropped element reports slot zero and a nonempty store.
  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sue_pkg::ST_FULL) |-> (position == '0) && (count != '0))
    else $error("full result with bad fields");

  // One request in flight: intake closes right after an acceptance.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count) &&
      $stable(position) && $stable(echo_value))
    else $error("stalled result changed");

endmodule

bind set_union_engine sue_checker u_sue_checker (.*);

[tb/sv/set_union_engine_tb.sv]
`timescale 1ns / 1ps

module set_union_engine_tb;

  localparam int DEPTH = sue_pkg::DEPTH_DEF;
  localparam int ELEM_W = sue_pkg::ELEM_WIDTH_DEF;
  localparam int N_ITEMS = 1300;
  // The spare command code has no name in the package; it acts as a second-list append.
  localparam logic [sue_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  // A second-list search walks all cells, plus both sides' longest stalls.
  localparam int STALL_LIMIT = 4 * (DEPTH + 2 + 8);

  typedef struct packed {
    logic [sue_pkg::CMD_W-1:0] op;
    logic [sue_pkg::VAL_W-1:0] val;
  } union_req_t;

  typedef struct packed {
    logic [sue_pkg::STS_W-1:0] st;
    logic [sue_pkg::VAL_W-1:0] echo;
    logic [sue_pkg::POS_W-1:0] slot;
    logic [sue_pkg::CNT_W-1:0] fill;
  } union_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [sue_pkg::CMD_W-1:0] cmd = sue_pkg::CMD_CLEAR;
  logic signed [sue_pkg::VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [sue_pkg::STS_W-1:0] status;
  logic signed [sue_pkg::VAL_W-1:0] echo_value;
  logic [sue_pkg::POS_W-1:0] position;
  logic [sue_pkg::CNT_W-1:0] count;

  // Requests waiting to be driven, and results predicted for accepted requests.
  union_req_t pending_reqs[$];
  union_result_t expected_results[$];
  logic [sue_pkg::VAL_W-1:0] seq_values[$];

  // Predictor copy of the stored list.
  logic [ELEM_W-1:0] union_store[DEPTH];
  int unsigned union_count = 0;

  int mismatches = 0;
  int pushed = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;

  set_union_engine #(
    .DEPTH(DEPTH),
    .ELEM_WIDTH(ELEM_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .echo_value(echo_value),
    .position(position),
    .count(count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one request and updates the predicted list.
  function automatic union_result_t predict_union(logic [sue_pkg::CMD_W-1:0] op,
                                                  logic [sue_pkg::VAL_W-1:0] val);
    union_result_t res;
    int hit;
    hit = -1;
    res.echo = val;
    res.slot = '0;
    if (op == sue_pkg::CMD_CLEAR) begin
      union_count = 0;
      res.st = sue_pkg::ST_CLEARED;
      res.echo = '0;
    end else begin
      // Only second-list requests (and the spare code) search for a match.
      if (op != sue_pkg::CMD_FIRST) begin
        for (int i = 0; i < union_count; i++) begin
          if (hit < 0 && union_store[i] == val) hit = i;
        end
      end
      if (hit >= 0) begin
        res.st = sue_pkg::ST_DUPLICATE;
        res.slot = hit[sue_pkg::POS_W-1:0];
      end else if (union_count >= DEPTH) begin
        res.st = sue_pkg::ST_FULL;
      end else begin
        union_store[union_count] = val;
        res.st = sue_pkg::ST_APPENDED;
        res.slot = union_count[sue_pkg::POS_W-1:0];
        union_count++;
      end
    end
    res.fill = union_count[sue_pkg::CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 100) begin
      $display("%0t ns: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  task automatic push_req(logic [sue_pkg::CMD_W-1:0] op, logic [sue_pkg::VAL_W-1:0] val);
    pending_reqs.push_back('{op: op, val: val});
    pushed++;
  endtask

  // Mostly random words, with small values and the extremes mixed in.
  function automatic logic [sue_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Picks a value already used in the current sequence, else a fresh one.
  function automatic logic [sue_pkg::VAL_W-1:0] reuse_value();
    if (seq_values.size() > 0) return seq_values[$urandom_range(0, seq_values.size() - 1)];
    return rand_value();
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Request driver: holds a request until it is taken, then idles a random gap.
  always @(negedge clk) begin
    logic next_valid;
    union_req_t req;
    next_valid = in_valid;
    if (!rst && (!in_valid || in_taken)) begin
      if (in_taken) begin
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end
      if (in_gap > 0) begin
        in_gap--;
        next_valid = 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        cmd <= req.op;
        value <= req.val;
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
  end

  // Result acceptor: stalls a random number of cycles while a result is offered.
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      out_hold = out_burst ? 0 : $urandom_range(0, 4);
    end
    out_ready <= !rst && (out_hold == 0);
    if (out_hold > 0 && out_valid) out_hold--;
  end

  // Monitor: predicts on accepted requests, checks accepted results, and
  // ends the run when no handshake happens for too long.
  always @(posedge clk) begin
    union_result_t want;
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_union(cmd, value));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", '0, {30'd0, status});
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st) report_mismatch("status", 32'(want.st), 32'(status));
          if (echo_value !== want.echo) report_mismatch("echo_value", want.echo, echo_value);
          if (position !== want.slot) report_mismatch("position", 32'(want.slot), 32'(position));
          if (count !== want.fill) report_mismatch("count", 32'(want.fill), 32'(count));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Stimulus: a directed list, then random sequences of union operations.
  initial begin
    int kind;
    int n_first;
    int n_second;
    int fills;
    int seq_no;
    logic [sue_pkg::CMD_W-1:0] op;

    fills = 0;
    seq_no = 0;

    // Directed: extremes, kept first-list duplicates, matches on second-list
    // and spare-code entries, an empty-list search and clears with a nonzero value.
    push_req(sue_pkg::CMD_CLEAR, 32'h1234_5678);
    push_req(sue_pkg::CMD_FIRST, 32'h0000_0000);
    push_req(sue_pkg::CMD_FIRST, 32'hFFFF_FFFF);
    push_req(sue_pkg::CMD_FIRST, 32'h8000_0000);
    push_req(sue_pkg::CMD_FIRST, 32'h7FFF_FFFF);
    push_req(sue_pkg::CMD_FIRST, 32'h7FFF_FFFF);
    push_req(sue_pkg::CMD_SECOND, 32'h7FFF_FFFF);
    push_req(sue_pkg::CMD_SECOND, 32'h8000_0000);
    push_req(sue_pkg::CMD_SECOND, 32'h5555_5555);
    push_req(CMD_SPARE, 32'hAAAA_AAAA);
    push_req(CMD_SPARE, 32'h5555_5555);
    push_req(sue_pkg::CMD_SECOND, 32'hAAAA_AAAA);
    push_req(sue_pkg::CMD_SECOND, 32'h0000_0001);
    push_req(sue_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    push_req(sue_pkg::CMD_SECOND, 32'h0000_0000);
    push_req(sue_pkg::CMD_FIRST, 32'h0000_0000);
    push_req(sue_pkg::CMD_SECOND, 32'h0000_0000);
    push_req(CMD_SPARE, 32'hFFFF_FFFF);
    push_req(sue_pkg::CMD_CLEAR, 32'h8000_0000);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Hold off new requests until every directed result is back.
    wait_drained();

    while (pushed < N_ITEMS) begin
      kind = $urandom_range(0, 19);
      seq_values.delete();
      if (seq_no == 2 || (kind == 0 && fills < 3)) begin
        // Fill the store past its capacity, then search it while full.
        fills++;
        push_req(sue_pkg::CMD_CLEAR, rand_value());
        repeat (DEPTH + $urandom_range(1, 4)) begin
          seq_values.push_back($urandom_range(0, 1) ? rand_value() : reuse_value());
          push_req(sue_pkg::CMD_FIRST, seq_values[$]);
        end
        push_req(sue_pkg::CMD_SECOND, reuse_value());
        push_req(CMD_SPARE, reuse_value());
        push_req(sue_pkg::CMD_SECOND, $urandom);
        push_req(CMD_SPARE, $urandom);
      end else if (kind < 15) begin
        // Well-formed union: usually a clear, a first list, then a second list.
        if ($urandom_range(0, 3) != 0) push_req(sue_pkg::CMD_CLEAR, rand_value());
        n_first = $urandom_range(0, 16);
        n_second = $urandom_range(1, 10);
        repeat (n_first) begin
          seq_values.push_back($urandom_range(0, 3) == 0 ? reuse_value() : rand_value());
          push_req(sue_pkg::CMD_FIRST, seq_values[$]);
        end
        repeat (n_second) begin
          op = ($urandom_range(0, 3) == 0) ? CMD_SPARE : sue_pkg::CMD_SECOND;
          seq_values.push_back($urandom_range(0, 1) ? reuse_value() : rand_value());
          push_req(op, seq_values[$]);
        end
      end else begin
        // Noise: any command with any value.
        repeat ($urandom_range(1, 6)) begin
          push_req(sue_pkg::CMD_W'($urandom_range(0, 3)), rand_value());
        end
      end
      seq_no++;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sue_pkg.sv
src/sue_cell.sv
src/set_union_engine.sv
src/sue_checker.sv
tb/sv/set_union_engine_tb.sv
